/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the postfix evaluator datapath, clocked on aclk
// and held off while aresetn is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PFX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition must never be true at a clock edge out of reset
`define PFX_ASSERT_NEVER(lbl, cond, msg) \
    `PFX_ASSERT(lbl, !(cond), msg)

`endif

/* src/pfx_pkg.sv */
// ---------------------------------------------------------------------------
// pfx_pkg
// Shared constants, types and helper functions of the postfix evaluator
// ---------------------------------------------------------------------------
package pfx_pkg;

    // sizes
    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH   = STACK_DEPTH - 1;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int WIDE_W      = VALUE_WIDTH + FRAC_BITS;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int DIV_STEPS   = WIDE_W;
    localparam int DIV_CW      = $clog2(DIV_STEPS);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [WIDE_W-1:0]      wide_t;

    // largest magnitudes that still fit a signed value
    localparam wide_t MAG_MAX_POS = {{(FRAC_BITS + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam wide_t MAG_MAX_NEG = {{FRAC_BITS{1'b0}}, 1'b1, {(VALUE_WIDTH - 1){1'b0}}};
    localparam value_t VALUE_MAX  = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam value_t VALUE_MIN  = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    // token kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 3'd0,
        FUNC_ADD  = 3'd1,
        FUNC_SUB  = 3'd2,
        FUNC_MUL  = 3'd3,
        FUNC_DIV  = 3'd4
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_UNDER   = 3'd1,
        STATUS_NOTONE  = 3'd2,
        STATUS_DIVZERO = 3'd3,
        STATUS_OVER    = 3'd4,
        STATUS_SAT     = 3'd5
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_PACK,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic div_step;
        logic pack;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
        logic out_blocked;
    } dp_stat_t;

    // saturated value and its flag
    typedef struct packed {
        logic   sat;
        value_t value;
    } pack_t;

    // absolute value of a two's complement word
    function automatic value_t magnitude(value_t v);
        value_t r;
        r = v[VALUE_WIDTH-1] ? (~v + value_t'(1)) : v;
        return r;
    endfunction

    // sign plus wide magnitude to a saturated signed word
    function automatic pack_t pack_wide(logic neg, wide_t mag);
        wide_t limit;
        wide_t lo;
        pack_t r;
        limit = neg ? MAG_MAX_NEG : MAG_MAX_POS;
        lo    = mag;
        r.sat = 1'b0;
        if (mag > limit) begin
            r.sat = 1'b1;
            lo    = limit;
        end
        r.value = neg ? (~lo[VALUE_WIDTH-1:0] + value_t'(1)) : lo[VALUE_WIDTH-1:0];
        return r;
    endfunction

    // sticky status: first hard error wins, saturation only until replaced
    function automatic status_t merge_status(status_t cur, status_t code);
        status_t r;
        r = cur;
        if (code != STATUS_OK) begin
            if (cur == STATUS_OK || (cur == STATUS_SAT && code != STATUS_SAT)) begin
                r = code;
            end
        end
        return r;
    endfunction

endpackage

/* src/pfx_datapath.sv */
// ---------------------------------------------------------------------------
// pfx_datapath
// Operand stack, add/sub, multiplier, bit-serial divider, status tracking
// and the output word register of the postfix evaluator
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfx_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfx_pkg::ctrl_cmd_t   cmd,
    output pfx_pkg::dp_stat_t    stat,
    input  logic [31:0]          s_tdata,   // [31:0] token_value
    input  logic [7:0]           s_tuser,   // [2:0] func, [7:3] zero
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [31:0] result_value
    output logic [7:0]           m_tuser    // [2:0] status, [7:3] zero
);

    // token registers
    logic [pfx_pkg::FUNC_W-1:0] func_reg;
    pfx_pkg::value_t            token_reg;
    logic                       last_reg;

    // stack state: top entry in a register, lower entries in memory
    logic [pfx_pkg::CNT_W-1:0]  count_reg;
    pfx_pkg::status_t           status_reg;
    pfx_pkg::value_t            top_reg;
    pfx_pkg::value_t            mem [pfx_pkg::MEM_DEPTH];
    pfx_pkg::value_t            opa_reg;

    // arithmetic registers
    pfx_pkg::wide_t             wide_reg;
    pfx_pkg::value_t            rem_reg;
    pfx_pkg::value_t            divisor_reg;
    logic [pfx_pkg::DIV_CW-1:0] div_cnt_reg;
    pfx_pkg::value_t            res_reg;
    logic                       sat_reg;
    logic                       dz_reg;

    // output word
    logic                       m_tvalid_reg;
    pfx_pkg::value_t            out_value_reg;
    pfx_pkg::status_t           out_status_reg;

    // combinational
    logic [pfx_pkg::MEM_AW-1:0] rd_addr;
    logic [pfx_pkg::MEM_AW-1:0] wr_addr;
    logic                       has_two;
    logic                       is_op;
    pfx_pkg::value_t            mag_a;
    pfx_pkg::value_t            mag_b;
    logic [pfx_pkg::VALUE_WIDTH:0] addsub_sum;
    pfx_pkg::value_t            addsub_value;
    logic                       addsub_ovf;
    logic [pfx_pkg::PROD_W-1:0] product;
    pfx_pkg::wide_t             product_wide;
    logic [pfx_pkg::VALUE_WIDTH:0] div_shift;
    logic [pfx_pkg::VALUE_WIDTH:0] div_diff;
    logic                       div_ge;
    pfx_pkg::pack_t             pack_res;
    pfx_pkg::status_t           err_code;
    pfx_pkg::status_t           status_a;
    pfx_pkg::status_t           status_b;
    logic [pfx_pkg::CNT_W-1:0]  count_a;
    pfx_pkg::value_t            top_a;
    logic                       mem_we;
    pfx_pkg::value_t            final_value;

    // token capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg  <= s_tuser[pfx_pkg::FUNC_W-1:0];
            token_reg <= s_tdata;
            last_reg  <= s_tlast;
        end
    end

    // stack memory: one write and one registered read
    assign rd_addr = pfx_pkg::MEM_AW'(count_reg - pfx_pkg::CNT_W'(2));
    assign wr_addr = pfx_pkg::MEM_AW'(count_reg - pfx_pkg::CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= top_reg;
        end
        if (cmd.accept) begin
            opa_reg <= mem[rd_addr];
        end
    end

    // operand decode
    assign has_two = (count_reg >= pfx_pkg::CNT_W'(2));
    assign is_op   = (func_reg == pfx_pkg::FUNC_ADD) || (func_reg == pfx_pkg::FUNC_SUB) ||
                     (func_reg == pfx_pkg::FUNC_MUL) || (func_reg == pfx_pkg::FUNC_DIV);
    assign mag_a   = pfx_pkg::magnitude(opa_reg);
    assign mag_b   = pfx_pkg::magnitude(top_reg);

    // saturating add and subtract
    always_comb begin
        if (func_reg == pfx_pkg::FUNC_SUB) begin
            addsub_sum = {opa_reg[pfx_pkg::VALUE_WIDTH-1], opa_reg} -
                         {top_reg[pfx_pkg::VALUE_WIDTH-1], top_reg};
        end else begin
            addsub_sum = {opa_reg[pfx_pkg::VALUE_WIDTH-1], opa_reg} +
                         {top_reg[pfx_pkg::VALUE_WIDTH-1], top_reg};
        end
        addsub_ovf = addsub_sum[pfx_pkg::VALUE_WIDTH] != addsub_sum[pfx_pkg::VALUE_WIDTH-1];
        if (addsub_ovf) begin
            addsub_value = addsub_sum[pfx_pkg::VALUE_WIDTH] ? pfx_pkg::VALUE_MIN
                                                            : pfx_pkg::VALUE_MAX;
        end else begin
            addsub_value = addsub_sum[pfx_pkg::VALUE_WIDTH-1:0];
        end
    end

    // magnitude product, fraction bits dropped
    assign product      = mag_a * mag_b;
    assign product_wide = pfx_pkg::WIDE_W'(product >> pfx_pkg::FRAC_BITS);

    // restoring divide step: numerator shifts out the top, quotient in the bottom
    assign div_shift = {rem_reg, wide_reg[pfx_pkg::WIDE_W-1]};
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});

    // sign and saturation of a wide magnitude
    assign pack_res = pfx_pkg::pack_wide(opa_reg[pfx_pkg::VALUE_WIDTH-1] ^
                                         top_reg[pfx_pkg::VALUE_WIDTH-1], wide_reg);

    // arithmetic sequencing
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            sat_reg <= 1'b0;
            dz_reg  <= 1'b0;
            case (func_reg) inside
                pfx_pkg::FUNC_ADD, pfx_pkg::FUNC_SUB: begin
                    res_reg <= addsub_value;
                    sat_reg <= addsub_ovf;
                end
                pfx_pkg::FUNC_MUL: begin
                    wide_reg <= product_wide;
                end
                pfx_pkg::FUNC_DIV: begin
                    if (top_reg == '0) begin
                        res_reg <= '0;
                        dz_reg  <= 1'b1;
                    end else begin
                        wide_reg    <= {mag_a, {pfx_pkg::FRAC_BITS{1'b0}}};
                        divisor_reg <= mag_b;
                        rem_reg     <= '0;
                        div_cnt_reg <= pfx_pkg::DIV_CW'(pfx_pkg::DIV_STEPS - 1);
                    end
                end
                default: ;
            endcase
        end else if (cmd.div_step) begin
            wide_reg    <= {wide_reg[pfx_pkg::WIDE_W-2:0], div_ge};
            rem_reg     <= div_ge ? div_diff[pfx_pkg::VALUE_WIDTH-1:0]
                                  : div_shift[pfx_pkg::VALUE_WIDTH-1:0];
            div_cnt_reg <= div_cnt_reg - pfx_pkg::DIV_CW'(1);
        end else if (cmd.pack) begin
            res_reg <= pack_res.value;
            sat_reg <= pack_res.sat;
        end
    end

    // token completion: stack update, status and final check
    always_comb begin
        err_code = pfx_pkg::STATUS_OK;
        count_a  = count_reg;
        top_a    = top_reg;
        mem_we   = 1'b0;
        if (func_reg == pfx_pkg::FUNC_PUSH) begin
            if (count_reg >= pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH)) begin
                err_code = pfx_pkg::STATUS_OVER;
            end else begin
                mem_we  = cmd.finish && (count_reg != '0);
                top_a   = token_reg;
                count_a = count_reg + pfx_pkg::CNT_W'(1);
            end
        end else if (is_op) begin
            if (!has_two) begin
                err_code = pfx_pkg::STATUS_UNDER;
            end else begin
                count_a = count_reg - pfx_pkg::CNT_W'(1);
                top_a   = res_reg;
                if (dz_reg) begin
                    err_code = pfx_pkg::STATUS_DIVZERO;
                end else if (sat_reg) begin
                    err_code = pfx_pkg::STATUS_SAT;
                end
            end
        end
        status_a = pfx_pkg::merge_status(status_reg, err_code);
        status_b = status_a;
        if (count_a != pfx_pkg::CNT_W'(1) &&
            (status_a == pfx_pkg::STATUS_OK || status_a == pfx_pkg::STATUS_SAT)) begin
            status_b = pfx_pkg::STATUS_NOTONE;
        end
        final_value = '0;
        if (status_b == pfx_pkg::STATUS_OK || status_b == pfx_pkg::STATUS_SAT) begin
            final_value = top_a;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            status_reg <= pfx_pkg::STATUS_OK;
        end else if (cmd.finish) begin
            if (last_reg) begin
                count_reg  <= '0;
                status_reg <= pfx_pkg::STATUS_OK;
            end else begin
                count_reg  <= count_a;
                status_reg <= status_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            top_reg <= top_a;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish && last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && last_reg) begin
            out_value_reg  <= final_value;
            out_status_reg <= status_b;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {{(8 - pfx_pkg::STATUS_W){1'b0}}, out_status_reg};

    // status to controller
    assign stat.need_mul    = (func_reg == pfx_pkg::FUNC_MUL) && has_two;
    assign stat.need_div    = (func_reg == pfx_pkg::FUNC_DIV) && has_two && (top_reg != '0);
    assign stat.div_last    = (div_cnt_reg == '0);
    assign stat.out_blocked = last_reg && m_tvalid_reg && !m_tready;

    // checks
    `PFX_ASSERT(a_clear_after_last, cmd.finish && last_reg |=> count_reg == '0 && status_reg == pfx_pkg::STATUS_OK, "stack not cleared after last token")
    `PFX_ASSERT_NEVER(a_count_bound, count_reg > pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH), "stack count beyond depth")
    `PFX_ASSERT_NEVER(a_error_value_zero, m_tvalid_reg && (out_status_reg == pfx_pkg::STATUS_UNDER || out_status_reg == pfx_pkg::STATUS_NOTONE || out_status_reg == pfx_pkg::STATUS_DIVZERO || out_status_reg == pfx_pkg::STATUS_OVER) && out_value_reg != '0, "error result carries a value")
    `PFX_ASSERT(a_div_nonzero, cmd.div_step |-> divisor_reg != '0, "divide step with zero divisor")

endmodule

/* src/pfx_ctrl.sv */
// ---------------------------------------------------------------------------
// pfx_ctrl
// Token sequencer: accept, execute, divide iterations, pack and completion
// ---------------------------------------------------------------------------
module pfx_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pfx_pkg::dp_stat_t   stat,
    output pfx_pkg::ctrl_cmd_t  cmd
);

    pfx_pkg::state_t state_reg;
    pfx_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfx_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfx_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = pfx_pkg::S_EXEC;
                end
            end
            pfx_pkg::S_EXEC: begin
                if (stat.need_div) begin
                    state_next = pfx_pkg::S_DIV;
                end else if (stat.need_mul) begin
                    state_next = pfx_pkg::S_PACK;
                end else begin
                    state_next = pfx_pkg::S_FINISH;
                end
            end
            pfx_pkg::S_DIV: begin
                if (stat.div_last) begin
                    state_next = pfx_pkg::S_PACK;
                end
            end
            pfx_pkg::S_PACK: begin
                state_next = pfx_pkg::S_FINISH;
            end
            pfx_pkg::S_FINISH: begin
                if (!stat.out_blocked) begin
                    state_next = pfx_pkg::S_IDLE;
                end
            end
            default: state_next = pfx_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            pfx_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            pfx_pkg::S_EXEC:   cmd.exec     = 1'b1;
            pfx_pkg::S_DIV:    cmd.div_step = 1'b1;
            pfx_pkg::S_PACK:   cmd.pack     = 1'b1;
            pfx_pkg::S_FINISH: cmd.finish   = !stat.out_blocked;
            default: ;
        endcase
    end

endmodule

/* src/postfix_expression_evaluator_top.sv */
// Push, add, subtract and ignored codes pass accept, execute and completion; multiply
// adds pack; divide adds the serial divider, one quotient bit per cycle over 48 bits.
// One token is in flight at a time; s_tready is high in the cycle after completion.
// The result word for a last token appears the cycle after its completion; a last
// token waits in completion while the previous result word is still unread.
// Synchronous active-low reset empties the stack and clears the status.
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Evaluates postfix Q16.16 expressions token by token on a 16-entry stack
// ---------------------------------------------------------------------------
module postfix_expression_evaluator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] token_value
    input  logic [7:0]  s_tuser,   // [2:0] func, [7:3] zero
    input  logic        s_tlast,   // last_token
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [7:0]  m_tuser    // [2:0] status, [7:3] zero
);

    pfx_pkg::ctrl_cmd_t cmd;
    pfx_pkg::dp_stat_t  stat;

    // sequencer
    pfx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack and arithmetic
    pfx_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
